@@ rtl/core/dkis_pkg.sv @@
// ----------------------------------------------------------------------------
// dkis_pkg
// Types and helpers used by the date key insertion sorter.
// ----------------------------------------------------------------------------
package dkis_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int TAG_W   = 4;
  localparam int KEY_W   = MONTH_W + DAY_W;

  typedef struct packed {
    logic [MONTH_W-1:0] due_month;
    logic [DAY_W-1:0]   due_day;
    logic [TAG_W-1:0]   record_tag;
    logic               last_in;
  } in_rec_t;

  typedef struct packed {
    logic [MONTH_W-1:0] sorted_month;
    logic [DAY_W-1:0]   sorted_day;
    logic [TAG_W-1:0]   sorted_tag;
    logic               last_out;
    logic               overflow;
  } out_rec_t;

  // One stored record, as it sits in the store memory.
  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_CMP,
    S_WRITE_NEW,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  // Month is the major key, day the minor key.
  function automatic logic [KEY_W-1:0] key_of(entry_t e);
    key_of = {e.month, e.day};
  endfunction

endpackage

@@ rtl/core/dkis_ram.sv @@
// ----------------------------------------------------------------------------
// dkis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dkis_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/date_key_insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// date_key_insertion_sorter
// Stable insertion sort of dated records over a single record memory.
// ----------------------------------------------------------------------------
// Records arrive one transfer at a time and are inserted in key order
// (month, then day) into a MAX_ENTRIES deep memory; equal keys keep their
// arrival order. Inserting a record takes a read step and a compare step for
// each stored record that gets compared: every stored record with a larger
// key and, unless all are larger, the first one that is not. The memory has one
// read and one write port with a registered read, and one key comparator walks
// the store from the top down, moving one entry per step. When the record
// marked last arrives, every stored record is sent out in order, one memory
// read each, held back by out_stall, with last_out on the final one and
// overflow on all of them if records past capacity were dropped in that batch.
// A dropped record still ends the batch when it carries last_in. in_stall is
// high while a record is being inserted or a batch is being sent out.
// ----------------------------------------------------------------------------
module date_key_insertion_sorter
  import dkis_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_rec_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rec_t out_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   k_r, k_nxt;
  entry_t          new_r, new_nxt;
  logic            last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_rec_t        out_data_r, out_data_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;

  logic            in_xfer;
  logic            slot_free;
  logic            out_load;
  logic            out_is_last;
  logic            key_greater;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || !out_stall;

  // The single key comparator: a stored key strictly above the new one moves up.
  assign key_greater = key_of(ram_rdata) > key_of(new_r);
  assign out_is_last = (CW'(k_r) + CW'(1)) == count_r;

  dkis_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    new_nxt       = new_r;
    last_nxt      = last_r;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = pos_r;
    ram_raddr     = pos_r - AW'(1);
    ram_wdata     = new_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          new_nxt.month = in_data.due_month;
          new_nxt.day   = in_data.due_day;
          new_nxt.tag   = in_data.record_tag;
          last_nxt      = in_data.last_in;
          k_nxt         = '0;
          if (count_r == CW'(MAX_ENTRIES)) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_data.last_in ? S_OUT_RD : S_IDLE;
          end else begin
            pos_nxt   = count_r[AW-1:0];
            state_nxt = (count_r == '0) ? S_WRITE_NEW : S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SHIFT_CMP;
      end
      S_SHIFT_CMP: begin
        if (key_greater) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - AW'(1);
          state_nxt = (pos_r == AW'(1)) ? S_WRITE_NEW : S_SHIFT_RD;
        end else begin
          state_nxt = S_WRITE_NEW;
        end
      end
      S_WRITE_NEW: begin
        ram_we    = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? S_OUT_RD : S_IDLE;
      end
      S_OUT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_r;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (slot_free) begin
          out_load                  = 1'b1;
          out_data_nxt.sorted_month = ram_rdata.month;
          out_data_nxt.sorted_day   = ram_rdata.day;
          out_data_nxt.sorted_tag   = ram_rdata.tag;
          out_data_nxt.last_out     = out_is_last;
          out_data_nxt.overflow     = ovf_r;
          if (out_is_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r      <= new_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  // The fill count never passes the capacity of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds capacity");

  // A shift step always has an entry below the insertion point to read.
  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RD) |-> (pos_r != '0))
    else $error("shift read with insertion point at the bottom");

  // While a batch is sent out, the read index stays inside the filled part.
  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_RD || state_r == S_OUT_LD) |-> (CW'(k_r) < count_r))
    else $error("output index beyond filled entries");

  // Sending the final result of a batch empties the store and clears overflow.
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_LD && slot_free && out_is_last)
      |=> (count_r == '0 && !ovf_r && state_r == S_IDLE))
    else $error("store not emptied after batch");

  // An insertion ends with the fill count one higher.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE_NEW) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insertion did not advance the fill count");

endmodule
